[hw/rtl/lcld_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and colour-stop tables for the load-to-colour LED driver.
package lcld_pkg;

    localparam int COUNTER_WIDTH_DEF = 64;

    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OFF_W      = 13;
    localparam int NUM_W      = 21;
    localparam int Y_W        = 12;
    localparam int CH_W       = 2;
    localparam int SEG_W      = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

    localparam logic [PCT_W-1:0] SLEW_STEP_RST   = 15'd256;
    localparam logic [PCT_W-1:0] BLINK_THR_RST   = 15'd25344;
    localparam logic [15:0]      HALF_PERIOD_RST = 16'd100;

    // Quotient bits of the load ratio (result is below 2^15)
    localparam int DIV_STEPS = 15;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int NUM_CH    = 3;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    localparam logic [SEG_W-1:0] SEG_FULL = 3'd5;

    // Reciprocals for division by 5 and by 15
    localparam logic [Y_W-1:0] RECIP_5  = 12'd3277;
    localparam logic [Y_W-1:0] RECIP_15 = 12'd2185;

    typedef struct packed {
        logic        kind;
        logic [63:0] idle_time;
        logic [63:0] kernel_time;
        logic [63:0] user_time;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [PCT_W-1:0] shown_percent;
        logic             alarm_blinking;
    } t_out;

    typedef struct packed {
        logic            capture;
        logic            diff;
        logic            tot;
        logic            act;
        logic            sat;
        logic            mul1;
        logic            mul2;
        logic            div_step;
        logic            div_last;
        logic            slew;
        logic            seg;
        logic            ch_num;
        logic            ch_scl;
        logic            ch_rec;
        logic [CH_W-1:0] ch_sel;
        logic            finish;
    } t_cmd;

    typedef struct packed {
        logic have_base;
        logic total_zero;
        logic act_ge;
        logic out_free;
    } t_stat;

    // Segment of the colour ramp for a display value
    function automatic logic [SEG_W-1:0] seg_of(input logic [PCT_W-1:0] d);
        logic [SEG_W-1:0] s;
        if (d <= 15'd2560)       s = 3'd0;
        else if (d <= 15'd5120)  s = 3'd1;
        else if (d <= 15'd12800) s = 3'd2;
        else if (d <= 15'd20480) s = 3'd3;
        else if (d < PCT_FULL)   s = 3'd4;
        else                     s = SEG_FULL;
        return s;
    endfunction

    function automatic logic [PCT_W-1:0] stop_at(input logic [SEG_W-1:0] s);
        logic [PCT_W-1:0] a;
        case (s)
            3'd0:    a = 15'd0;
            3'd1:    a = 15'd2560;
            3'd2:    a = 15'd5120;
            3'd3:    a = 15'd12800;
            3'd4:    a = 15'd20480;
            default: a = PCT_FULL;
        endcase
        return a;
    endfunction

    function automatic logic [OFF_W-1:0] seg_span(input logic [SEG_W-1:0] s);
        logic [OFF_W-1:0] sp;
        case (s)
            3'd2, 3'd3: sp = 13'd7680;
            3'd4:       sp = 13'd5120;
            default:    sp = 13'd2560;
        endcase
        return sp;
    endfunction

    // Twice the span is 2^11 * 5 only on the last segment, 2^10 * 5 or 2^10 * 15 elsewhere
    function automatic logic seg_shift11(input logic [SEG_W-1:0] s);
        return s == 3'd4;
    endfunction

    function automatic logic seg_div15(input logic [SEG_W-1:0] s);
        return (s == 3'd2) || (s == 3'd3);
    endfunction

    function automatic logic [7:0] stop_colour(input logic [SEG_W-1:0] k,
                                               input logic [CH_W-1:0] ch);
        logic [7:0] c;
        case (k)
            3'd0, 3'd1: c = (ch == CH_RED) ? 8'd135 : (ch == CH_GREEN) ? 8'd206 : 8'd235;
            3'd2:       c = (ch == CH_BLUE) ? 8'd255 : 8'd0;
            3'd3:       c = (ch == CH_GREEN) ? 8'd255 : 8'd0;
            3'd4:       c = (ch == CH_BLUE) ? 8'd0 : 8'd255;
            default:    c = (ch == CH_RED) ? 8'd255 : 8'd0;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/load_to_color_led_driver_core.sv]
`timescale 1ns / 1ps
// Top level of the load-to-colour LED driver: sequencer plus datapath.
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (lcld_pkg::t_in)
//  out       output     o_out_valid / i_out_ready  o_out_data (lcld_pkg::t_out)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// The first sample item only sets the base; later ones run total and active, then
// the 15-step restoring divider unless total is zero or active saturates.
// A frame runs slew, ramp segment, then numerator, scale and reciprocal per colour
// channel. One item is handled at a time; a frame waits in its last step while the
// output register still holds an item not taken. Reset is synchronous, active low.
module load_to_color_led_driver_core #(
    parameter int COUNTER_WIDTH = lcld_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lcld_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lcld_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_we,
    input  logic [lcld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcld_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lcld_pkg::t_cmd  cmd;
    lcld_pkg::t_stat stat;

    lcld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_in_data.kind),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lcld_dp #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[hw/rtl/lcld_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the load-to-colour LED driver: steps the datapath through each item.
module lcld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    input  lcld_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output lcld_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_TOT   = 4'd2;
    localparam logic [3:0] ST_ACT   = 4'd3;
    localparam logic [3:0] ST_MUL1  = 4'd4;
    localparam logic [3:0] ST_MUL2  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SLEW  = 4'd7;
    localparam logic [3:0] ST_SEG   = 4'd8;
    localparam logic [3:0] ST_NUM   = 4'd9;
    localparam logic [3:0] ST_SCL   = 4'd10;
    localparam logic [3:0] ST_REC   = 4'd11;
    localparam logic [3:0] ST_BLINK = 4'd12;

    localparam logic [lcld_pkg::CNT_W-1:0] DIV_LAST =
        lcld_pkg::CNT_W'(lcld_pkg::DIV_STEPS - 1);
    localparam logic [lcld_pkg::CNT_W-1:0] CH_LAST =
        lcld_pkg::CNT_W'(lcld_pkg::NUM_CH - 1);

    logic [3:0]                 r_state, n_state;
    logic [lcld_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.ch_sel = r_cnt[lcld_pkg::CH_W-1:0];
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_kind ? ST_SLEW : ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = i_stat.have_base ? ST_TOT : ST_IDLE;
            end
            ST_TOT: begin
                o_cmd.tot = 1'b1;
                n_state = ST_ACT;
            end
            ST_ACT: begin
                o_cmd.act = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                // zero total keeps the old load; active not below total saturates
                if (i_stat.total_zero) begin
                    n_state = ST_IDLE;
                end else if (i_stat.act_ge) begin
                    o_cmd.sat = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.mul1 = 1'b1;
                    n_state = ST_MUL2;
                end
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_cnt = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SLEW: begin
                o_cmd.slew = 1'b1;
                n_state = ST_SEG;
            end
            ST_SEG: begin
                o_cmd.seg = 1'b1;
                n_cnt = '0;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.ch_num = 1'b1;
                n_state = ST_SCL;
            end
            ST_SCL: begin
                o_cmd.ch_scl = 1'b1;
                n_state = ST_REC;
            end
            ST_REC: begin
                o_cmd.ch_rec = 1'b1;
                n_cnt = r_cnt + 1'b1;
                n_state = (r_cnt == CH_LAST) ? ST_BLINK : ST_NUM;
            end
            ST_BLINK: begin
                // hold until the output register can take the item
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lcld_dp.sv]
`timescale 1ns / 1ps
// Datapath for the load-to-colour LED driver: load ratio, slew, colour ramp, blink and output.
module lcld_dp #(
    parameter int COUNTER_WIDTH = lcld_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lcld_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcld_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  lcld_pkg::t_in                   i_in_data,
    input  lcld_pkg::t_cmd                  i_cmd,
    output lcld_pkg::t_stat                 o_stat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lcld_pkg::t_out                  o_out_data
);

    localparam int CW = COUNTER_WIDTH;
    localparam int PW = lcld_pkg::PCT_W;

    // configuration
    logic [PW-1:0] r_slew_step, r_blink_thr;
    logic [15:0]   r_half_period;

    // load measurement
    logic [CW-1:0]   r_ci, r_ck, r_cu;
    logic [CW-1:0]   r_prev_i, r_prev_k, r_prev_u;
    logic            r_have_base;
    logic [CW-1:0]   r_di, r_dk, r_du;
    logic [CW-1:0]   r_total, r_active;
    logic [CW+4:0]   r_sum;
    logic [CW-1:0]   r_rem;
    logic [PW-1:0]   r_nlo, r_quo;
    logic [PW-1:0]   r_measured;

    // display
    logic [31:0]                    r_now, r_last_toggle;
    logic [PW-1:0]                  r_display;
    logic [lcld_pkg::SEG_W-1:0]     r_seg;
    logic [lcld_pkg::OFF_W-1:0]     r_off;
    logic                           r_over;
    logic [lcld_pkg::NUM_W-1:0]     r_num;
    logic [lcld_pkg::Y_W-1:0]       r_y;
    logic [7:0]                     r_red, r_green, r_blue;
    logic                           r_phase;
    logic                           r_out_valid;
    lcld_pkg::t_out                 r_out;

    // combinational intermediates
    logic [CW+4:0]                  n_a25;
    logic [CW:0]                    n_shl, n_shl_sub;
    logic                           n_ge;
    logic [PW-1:0]                  n_quo;
    logic [PW-1:0]                  n_diff_abs, n_display;
    logic [lcld_pkg::SEG_W-1:0]     n_seg, n_seg_b;
    logic [PW-1:0]                  n_off_full;
    logic [lcld_pkg::OFF_W-1:0]     n_span;
    logic [7:0]                     n_ca, n_cb;
    logic [lcld_pkg::NUM_W-1:0]     n_num;
    logic [22:0]                    n_y2;
    logic [lcld_pkg::Y_W-1:0]       n_recip;
    logic [23:0]                    n_prod;
    logic [7:0]                     n_q;
    logic [31:0]                    n_elapsed;
    logic                           n_toggle, n_phase;
    logic                           out_free;

    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.have_base  = r_have_base;
    assign o_stat.total_zero = (r_total == '0);
    assign o_stat.act_ge     = (r_active >= r_total);
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // load ratio: active * 25 via shift-add, then one quotient bit per step
    assign n_a25     = r_sum + {5'b0, r_active};
    assign n_shl     = {r_rem, r_nlo[PW-1]};
    assign n_ge      = (n_shl >= {1'b0, r_total});
    assign n_shl_sub = n_shl - {1'b0, r_total};
    assign n_quo     = {r_quo[PW-2:0], n_ge};

    // slew toward the measured load
    always_comb begin
        n_diff_abs = (r_measured >= r_display) ? (r_measured - r_display)
                                               : (r_display - r_measured);
        if (n_diff_abs <= r_slew_step)      n_display = r_measured;
        else if (r_measured > r_display)    n_display = r_display + r_slew_step;
        else                                n_display = r_display - r_slew_step;
    end

    // colour ramp
    assign n_seg      = lcld_pkg::seg_of(r_display);
    assign n_off_full = r_display - lcld_pkg::stop_at(n_seg);
    assign n_span     = lcld_pkg::seg_span(r_seg);
    assign n_seg_b    = (r_seg == lcld_pkg::SEG_FULL) ? r_seg : r_seg + 1'b1;
    assign n_ca       = lcld_pkg::stop_colour(r_seg, i_cmd.ch_sel);
    assign n_cb       = lcld_pkg::stop_colour(n_seg_b, i_cmd.ch_sel);
    assign n_num      = ({13'b0, n_ca} * {8'b0, n_span - r_off})
                      + ({13'b0, n_cb} * {8'b0, r_off});
    assign n_y2       = {1'b0, r_num, 1'b0} + {10'b0, n_span};
    assign n_recip    = lcld_pkg::seg_div15(r_seg) ? lcld_pkg::RECIP_15 : lcld_pkg::RECIP_5;
    assign n_prod     = {12'b0, r_y} * {12'b0, n_recip};
    assign n_q        = lcld_pkg::seg_div15(r_seg) ? n_prod[22:15] : n_prod[21:14];

    // blink timing
    assign n_elapsed = r_now - r_last_toggle;
    assign n_toggle  = r_over && (n_elapsed >= {16'b0, r_half_period});
    assign n_phase   = r_over && (n_toggle ? !r_phase : r_phase);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_step   <= lcld_pkg::SLEW_STEP_RST;
            r_blink_thr   <= lcld_pkg::BLINK_THR_RST;
            r_half_period <= lcld_pkg::HALF_PERIOD_RST;
            r_prev_i      <= '0;
            r_prev_k      <= '0;
            r_prev_u      <= '0;
            r_have_base   <= 1'b0;
            r_measured    <= '0;
            r_display     <= '0;
            r_phase       <= 1'b0;
            r_last_toggle <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lcld_pkg::CFG_SLEW_STEP:   r_slew_step   <= i_cfg_data[PW-1:0];
                    lcld_pkg::CFG_BLINK_THR:   r_blink_thr   <= i_cfg_data[PW-1:0];
                    lcld_pkg::CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.diff) begin
                r_prev_i    <= r_ci;
                r_prev_k    <= r_ck;
                r_prev_u    <= r_cu;
                r_have_base <= 1'b1;
            end
            if (i_cmd.sat) begin
                r_measured <= lcld_pkg::PCT_FULL;
            end
            if (i_cmd.div_last) begin
                r_measured <= n_quo;
            end
            if (i_cmd.slew) begin
                r_display <= n_display;
            end
            if (i_cmd.finish) begin
                r_phase <= n_phase;
                if (n_toggle) begin
                    r_last_toggle <= r_now;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ci  <= i_in_data.idle_time[CW-1:0];
            r_ck  <= i_in_data.kernel_time[CW-1:0];
            r_cu  <= i_in_data.user_time[CW-1:0];
            r_now <= i_in_data.now_ms;
        end
        if (i_cmd.diff) begin
            r_di <= r_ci - r_prev_i;
            r_dk <= r_ck - r_prev_k;
            r_du <= r_cu - r_prev_u;
        end
        if (i_cmd.tot) begin
            r_total <= r_dk + r_du;
        end
        if (i_cmd.act) begin
            r_active <= r_total - r_di;
        end
        if (i_cmd.mul1) begin
            r_sum <= {1'b0, r_active, 4'b0} + {2'b0, r_active, 3'b0};
        end
        if (i_cmd.mul2) begin
            // the quotient fits 15 bits, so the high part is already below the total
            r_rem <= n_a25[CW+4:5];
            r_nlo <= {n_a25[4:0], 10'b0};
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= n_ge ? n_shl_sub[CW-1:0] : n_shl[CW-1:0];
            r_nlo <= {r_nlo[PW-2:0], 1'b0};
            r_quo <= n_quo;
        end
        if (i_cmd.seg) begin
            r_seg  <= n_seg;
            r_off  <= (n_seg == lcld_pkg::SEG_FULL) ? '0 : n_off_full[lcld_pkg::OFF_W-1:0];
            r_over <= (r_display >= r_blink_thr);
        end
        if (i_cmd.ch_num) begin
            r_num <= n_num;
        end
        if (i_cmd.ch_scl) begin
            r_y <= lcld_pkg::seg_shift11(r_seg) ? n_y2[22:11] : n_y2[21:10];
        end
        if (i_cmd.ch_rec) begin
            case (i_cmd.ch_sel)
                lcld_pkg::CH_RED:   r_red   <= n_q;
                lcld_pkg::CH_GREEN: r_green <= n_q;
                default:            r_blue  <= n_q;
            endcase
        end
        if (i_cmd.finish) begin
            r_out.red            <= r_over ? (n_phase ? 8'd255 : 8'd0) : r_red;
            r_out.green          <= r_over ? 8'd0 : r_green;
            r_out.blue           <= r_over ? 8'd0 : r_blue;
            r_out.shown_percent  <= r_display;
            r_out.alarm_blinking <= r_over;
        end
    end

`ifndef ASSERT_OFF
    a_measured_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_measured <= lcld_pkg::PCT_FULL)
        else $error("measured load above full scale");

    a_display_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_display <= lcld_pkg::PCT_FULL)
        else $error("display value above full scale");

    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_total))
        else $error("division remainder not below total");

    a_alarm_red_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alarm_blinking) |-> (r_out.green == 8'd0 && r_out.blue == 8'd0))
        else $error("alarm item carries green or blue");

    a_finish_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> out_free)
        else $error("output register overwritten while occupied");
`endif

endmodule
